// File: src/psd_pkg.sv
// psd_pkg: widths and payload types for the point-segment distance pipeline.
// No dependencies.
`timescale 1ns / 1ps
package psd_pkg;
	localparam int CW = 32;              // coordinate width
	localparam int DW = CW + 1;          // difference width
	localparam int PW = 16;              // parameter fraction bits
	localparam int SQW = 2 * DW + 1;     // sum of squares width
	localparam int RW = CW + 1;          // root width
	localparam int IN_W = 6 * CW;
	localparam int OUT_BYTES = (RW + 2 * CW + PW + 1 + 7) / 8;
	localparam int OUT_W = OUT_BYTES * 8;
endpackage

// File: src/point_segment_distance.sv
// point_segment_distance: pipelined nearest point on a segment and distance to it.
// Depends on psd_pkg.
//
// channel | dir | fields (low bit first)
// s_axis  | in  | tdata: query_x, query_y, start_x, start_y, end_x, end_y (32b each)
// m_axis  | out | tdata: dist_res(33) foot_x(32) foot_y(32) segment_param(17);
//         |     | tuser: degenerate(1)
//
// One transfer per cycle sustained while m_axis_tready stays high. Pipeline stages:
// 4 setup stages, 16 divider stages (one quotient bit each), 3 foot stages,
// 1 squaring stage, 33 root stages (one result bit each), and the output register.
// Reset clears valid bits only. A stall freezes the whole pipeline in place.
`timescale 1ns / 1ps
module point_segment_distance (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [psd_pkg::IN_W-1:0] s_axis_tdata,   // qx, qy, sx, sy, ex, ey
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [psd_pkg::OUT_W-1:0] m_axis_tdata,  // dist, fx, fy, param
	output logic m_axis_tuser                        // degenerate
);
	localparam int CW = psd_pkg::CW;
	localparam int DW = psd_pkg::DW;
	localparam int PW = psd_pkg::PW;
	localparam int SQW = psd_pkg::SQW;
	localparam int RW = psd_pkg::RW;
	localparam int NDIV = PW;
	localparam int NSQ = RW;
	localparam int NST = 4 + NDIV + 3 + 1 + NSQ;

	// whole pipeline advances together; output register is the last stage
	logic adv;
	logic [NST:0] vld_q;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_q[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-1:0], s_axis_tvalid};
		end
	end

	// ---- stage 1: differences
	logic signed [CW-1:0] sx_s1, sy_s1, qx_s1, qy_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, ax_s1, ay_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			qx_s1 <= s_axis_tdata[0*CW +: CW];
			qy_s1 <= s_axis_tdata[1*CW +: CW];
			sx_s1 <= s_axis_tdata[2*CW +: CW];
			sy_s1 <= s_axis_tdata[3*CW +: CW];
			dx_s1 <= DW'($signed(s_axis_tdata[4*CW +: CW])) - DW'($signed(s_axis_tdata[2*CW +: CW]));
			dy_s1 <= DW'($signed(s_axis_tdata[5*CW +: CW])) - DW'($signed(s_axis_tdata[3*CW +: CW]));
			ax_s1 <= DW'($signed(s_axis_tdata[0*CW +: CW])) - DW'($signed(s_axis_tdata[2*CW +: CW]));
			ay_s1 <= DW'($signed(s_axis_tdata[1*CW +: CW])) - DW'($signed(s_axis_tdata[3*CW +: CW]));
		end
	end

	// ---- stage 2: four products
	localparam int PRW = 2 * DW;
	logic signed [PRW-1:0] pxx_s2, pyy_s2, pax_s2, pay_s2;
	logic signed [CW-1:0] sx_s2, sy_s2, qx_s2, qy_s2;
	logic signed [DW-1:0] dx_s2, dy_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			pxx_s2 <= PRW'(dx_s1) * PRW'(dx_s1);
			pyy_s2 <= PRW'(dy_s1) * PRW'(dy_s1);
			pax_s2 <= PRW'(ax_s1) * PRW'(dx_s1);
			pay_s2 <= PRW'(ay_s1) * PRW'(dy_s1);
			{sx_s2, sy_s2, qx_s2, qy_s2, dx_s2, dy_s2} <=
				{sx_s1, sy_s1, qx_s1, qy_s1, dx_s1, dy_s1};
		end
	end

	// ---- stage 3: den and num sums
	localparam int NW = PRW + 1;
	logic [NW-1:0] den_s3;
	logic signed [NW-1:0] num_s3;
	logic signed [CW-1:0] sx_s3, sy_s3, qx_s3, qy_s3;
	logic signed [DW-1:0] dx_s3, dy_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			den_s3 <= NW'($unsigned(pxx_s2)) + NW'($unsigned(pyy_s2));
			num_s3 <= NW'(pax_s2) + NW'(pay_s2);
			{sx_s3, sy_s3, qx_s3, qy_s3, dx_s3, dy_s3} <=
				{sx_s2, sy_s2, qx_s2, qy_s2, dx_s2, dy_s2};
		end
	end

	// ---- stage 4: classify; start divider remainder
	typedef struct packed {
		logic signed [CW-1:0] sx, sy, qx, qy;
		logic signed [DW-1:0] dx, dy;
		logic deg;
		logic sat;          // t already decided (0 or 1)
		logic [PW:0] t;
		logic [NW-1:0] rem;
		logic [NW-1:0] den;
	} div_t;
	div_t div_q [0:NDIV];
	always_ff @(posedge clk) begin
		if (adv) begin
			div_q[0].sx <= sx_s3; div_q[0].sy <= sy_s3;
			div_q[0].qx <= qx_s3; div_q[0].qy <= qy_s3;
			div_q[0].dx <= dx_s3; div_q[0].dy <= dy_s3;
			div_q[0].deg <= (dx_s3 == '0) && (dy_s3 == '0);
			div_q[0].den <= den_s3;
			div_q[0].rem <= num_s3;
			if (num_s3[NW-1] || num_s3 == '0) begin
				div_q[0].sat <= 1'b1;
				div_q[0].t <= '0;
			end else if ($unsigned(num_s3) >= den_s3) begin
				div_q[0].sat <= 1'b1;
				div_q[0].t <= (PW+1)'(1) << PW;
			end else begin
				div_q[0].sat <= 1'b0;
				div_q[0].t <= '0;
			end
		end
	end

	// ---- divider: one quotient bit per stage (rem < den, so 2*rem fits NW+1)
	for (genvar i = 0; i < NDIV; i++) begin : g_div
		logic [NW:0] r2;
		logic ge;
		div_t nxt;
		assign r2 = {div_q[i].rem, 1'b0};
		assign ge = r2 >= {1'b0, div_q[i].den};
		always_comb begin
			nxt = div_q[i];
			if (!div_q[i].sat) begin
				nxt.t = {div_q[i].t[PW-1:0], ge};
				nxt.rem = ge ? NW'(r2 - {1'b0, div_q[i].den}) : NW'(r2);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				div_q[i+1] <= nxt;
			end
		end
	end

	// ---- foot stage a: offset products
	localparam int MW = DW + PW + 1;
	div_t dv;
	assign dv = div_q[NDIV];
	logic [DW-1:0] mx, my;
	assign mx = dv.dx[DW-1] ? DW'(-dv.dx) : DW'(dv.dx);
	assign my = dv.dy[DW-1] ? DW'(-dv.dy) : DW'(dv.dy);
	logic [MW-1:0] ox_f1, oy_f1;
	logic nx_f1, ny_f1, deg_f1;
	logic [PW:0] t_f1;
	logic signed [CW-1:0] sx_f1, sy_f1, qx_f1, qy_f1;
	always_ff @(posedge clk) begin
		if (adv) begin
			ox_f1 <= MW'(mx) * MW'(dv.t);
			oy_f1 <= MW'(my) * MW'(dv.t);
			nx_f1 <= dv.dx[DW-1];
			ny_f1 <= dv.dy[DW-1];
			deg_f1 <= dv.deg;
			t_f1 <= dv.deg ? '0 : dv.t;
			{sx_f1, sy_f1, qx_f1, qy_f1} <= {dv.sx, dv.sy, dv.qx, dv.qy};
		end
	end

	// ---- foot stage b: foot point
	logic signed [CW-1:0] fx_f2, fy_f2, qx_f2, qy_f2;
	logic deg_f2;
	logic [PW:0] t_f2;
	always_ff @(posedge clk) begin
		if (adv) begin
			fx_f2 <= nx_f1 ? sx_f1 - CW'(ox_f1 >> PW) : sx_f1 + CW'(ox_f1 >> PW);
			fy_f2 <= ny_f1 ? sy_f1 - CW'(oy_f1 >> PW) : sy_f1 + CW'(oy_f1 >> PW);
			{qx_f2, qy_f2, deg_f2, t_f2} <= {qx_f1, qy_f1, deg_f1, t_f1};
		end
	end

	// ---- foot stage c: residual vector
	logic signed [DW-1:0] rx_f3, ry_f3;
	logic signed [CW-1:0] fx_f3, fy_f3;
	logic deg_f3;
	logic [PW:0] t_f3;
	always_ff @(posedge clk) begin
		if (adv) begin
			rx_f3 <= DW'(qx_f2) - DW'(fx_f2);
			ry_f3 <= DW'(qy_f2) - DW'(fy_f2);
			{fx_f3, fy_f3, deg_f3, t_f3} <= {fx_f2, fy_f2, deg_f2, t_f2};
		end
	end

	// ---- root: first stage squares, then one result bit per stage
	typedef struct packed {
		logic [SQW-1:0] v;
		logic [RW-1:0] res;
		logic signed [CW-1:0] fx, fy;
		logic deg;
		logic [PW:0] t;
	} sq_t;
	sq_t sq_q [0:NSQ];
	logic [DW-1:0] mrx, mry;
	assign mrx = rx_f3[DW-1] ? DW'(-rx_f3) : DW'(rx_f3);
	assign mry = ry_f3[DW-1] ? DW'(-ry_f3) : DW'(ry_f3);
	// squares split: register the two products, sum in the first root stage
	logic [2*DW-1:0] sqx_f4, sqy_f4;
	sq_t sq_in;
	always_comb begin
		sq_in = sq_q[0];
		sq_in.v = SQW'(sqx_f4) + SQW'(sqy_f4);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_f4 <= (2*DW)'(mrx) * (2*DW)'(mrx);
			sqy_f4 <= (2*DW)'(mry) * (2*DW)'(mry);
			sq_q[0].v <= '0;
			sq_q[0].res <= '0;
			sq_q[0].fx <= fx_f3;
			sq_q[0].fy <= fy_f3;
			sq_q[0].deg <= deg_f3;
			sq_q[0].t <= t_f3;
		end
	end
	// stage k decides bit RW-1-k; v holds remaining v - res^2 tracked directly
	for (genvar k = 0; k < NSQ; k++) begin : g_sq
		localparam int B = RW - 1 - k;
		sq_t cur;
		sq_t nxt;
		logic [SQW+1:0] cand;
		logic [SQW+1:0] vv;
		assign cur = (k == 0) ? sq_in : sq_q[k];
		// (res + 2^B)^2 - res^2 = res*2^(B+1) + 2^(2B)
		assign cand = ((SQW+2)'(cur.res) << (B + 1)) + ((SQW+2)'(1) << (2 * B));
		assign vv = (SQW+2)'(cur.v);
		always_comb begin
			nxt = cur;
			if (vv >= cand) begin
				nxt.v = SQW'(vv - cand);
				nxt.res = cur.res | (RW'(1) << B);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_q[k+1] <= nxt;
			end
		end
	end

	// output register; degenerate flag travels on tuser
	sq_t fin;
	assign fin = sq_q[NSQ];
	logic [psd_pkg::OUT_W-1:0] out_q;
	logic user_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= psd_pkg::OUT_W'({fin.t, fin.fy, fin.fx,
				fin.deg ? RW'(0) : fin.res});
			user_q <= fin.deg;
		end
	end
	assign m_axis_tdata = out_q;
	assign m_axis_tuser = user_q;
endmodule

// File: tb/tb_top.sv
// tb_top: self-checking bench for point_segment_distance (stream in, stream out).
// Depends on psd_pkg and the point_segment_distance RTL.
`timescale 1ns / 1ps
module tb_top;
	localparam int CW = psd_pkg::CW;
	localparam int RW = psd_pkg::RW;
	localparam int IN_W = psd_pkg::IN_W;
	localparam int OUT_W = psd_pkg::OUT_W;

	typedef struct {
		logic signed [CW-1:0] qx, qy, sx, sy, ex, ey;
		bit hold;                        // marker: sender waits for a full drain
	} query_t;

	typedef struct {
		logic [RW-1:0] dist_res;
		logic [CW-1:0] fx, fy;
		logic [16:0] param;
		logic degen;
	} nearest_t;

	localparam int LIMIT = 400000;
	localparam int CALM_TAIL = 150;      // last items go without idling

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic m_tuser;

	query_t pending_q[$];
	nearest_t nearest_q[$];
	int errors = 0, checked = 0, cycles = 0;
	int n_degen = 0, n_low = 0, n_high = 0, n_mid = 0;
	int src_gap = 0, snk_gap = 0;
	bit took = 0, holding = 0, stim_done = 0;

	point_segment_distance dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata(s_tdata),      // qx, qy, sx, sy, ex, ey
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata(m_tdata),      // dist, fx, fy, param
		.m_axis_tuser(m_tuser)       // degenerate
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Exact nearest point: clamp t to [0,1] in Q0.16, then foot and floor root.
	function automatic nearest_t nearest_point(query_t q);
		nearest_t r;
		longint dx, dy, fx, fy, rx, ry;
		logic signed [127:0] num, den, t, ox, oy, sq;
		logic [127:0] c, root;
		dx = longint'(q.ex) - longint'(q.sx);
		dy = longint'(q.ey) - longint'(q.sy);
		if (dx == 0 && dy == 0) begin
			r.dist_res = '0;
			r.fx = q.sx;
			r.fy = q.sy;
			r.param = '0;
			r.degen = 1'b1;
			return r;
		end
		den = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
		num = 128'(longint'(q.qx) - longint'(q.sx)) * 128'(dx)
			+ 128'(longint'(q.qy) - longint'(q.sy)) * 128'(dy);
		if (num <= 0) t = 0;
		else if (num >= den) t = 65536;
		else t = (num <<< 16) / den;
		ox = (128'(dx < 0 ? -dx : dx) * t) >>> 16;
		oy = (128'(dy < 0 ? -dy : dy) * t) >>> 16;
		fx = dx < 0 ? longint'(q.sx) - longint'(ox) : longint'(q.sx) + longint'(ox);
		fy = dy < 0 ? longint'(q.sy) - longint'(oy) : longint'(q.sy) + longint'(oy);
		rx = longint'(q.qx) - fx;
		ry = longint'(q.qy) - fy;
		sq = 128'(rx) * 128'(rx) + 128'(ry) * 128'(ry);
		root = '0;
		for (int b = RW - 1; b >= 0; b--) begin
			c = root | (128'd1 << b);
			if (c * c <= sq) root = c;
		end
		r.dist_res = root[RW-1:0];
		r.fx = fx[CW-1:0];
		r.fy = fy[CW-1:0];
		r.param = t[16:0];
		r.degen = 1'b0;
		return r;
	endfunction

	task automatic report(string what, logic [127:0] got, logic [127:0] want);
		errors++;
		$display("mismatch #%0d at result %0d: %s got %0h expected %0h",
			errors, checked, what, got, want);
	endtask

	function automatic query_t mk(longint qx, qy, sx, sy, ex, ey);
		query_t q;
		q.qx = qx[CW-1:0]; q.qy = qy[CW-1:0];
		q.sx = sx[CW-1:0]; q.sy = sy[CW-1:0];
		q.ex = ex[CW-1:0]; q.ey = ey[CW-1:0];
		q.hold = 0;
		return q;
	endfunction

	// Coordinate mix: full range, small values near the origin, or an extreme.
	function automatic longint rnd_coord(int mode);
		case (mode)
			0: return longint'($signed($urandom));
			1: return longint'($urandom_range(0, 1 << 22)) - (1 << 21);
			default: return $urandom_range(0, 1) ? 64'sh7fffffff : -64'sh80000000;
		endcase
	endfunction

	function automatic query_t rnd_query();
		query_t q;
		int mode, kind;
		mode = $urandom_range(0, 9) < 5 ? 0 : ($urandom_range(0, 9) < 8 ? 1 : 2);
		q = mk(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
			rnd_coord(mode), rnd_coord(mode), rnd_coord(mode));
		kind = $urandom_range(0, 19);
		if (kind == 0) begin                 // zero-length segment
			q.ex = q.sx;
			q.ey = q.sy;
		end else if (kind < 3) begin         // query right on an end point
			q.qx = $urandom_range(0, 1) ? q.sx : q.ex;
			q.qy = (q.qx == q.sx) ? q.sy : q.ey;
		end else if (kind < 5) begin         // axis-aligned segment
			q.ey = q.sy;
		end
		return q;
	endfunction

	// Sender: falling edge, next item only after the previous transfer.
	always @(negedge clk) begin
		if (arst_n && (took || !s_tvalid)) begin
			query_t q;
			if (!holding && pending_q.size() > 0 && pending_q[0].hold) begin
				void'(pending_q.pop_front());
				holding = 1;
			end
			if (holding && nearest_q.size() == 0) holding = 0;
			if (src_gap == 0 && pending_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
				src_gap = $urandom_range(1, 14);
			if (holding || src_gap > 0 || pending_q.size() == 0) begin
				if (src_gap > 0) src_gap--;
				s_tvalid <= 1'b0;
			end else begin
				q = pending_q.pop_front();
				s_tdata <= {q.ey, q.ex, q.sy, q.sx, q.qy, q.qx};
				s_tvalid <= 1'b1;
			end
		end
	end

	// Receiver: random stall bursts, steady ready in the tail.
	always @(negedge clk) begin
		if (arst_n) begin
			if (snk_gap == 0 && pending_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
				snk_gap = $urandom_range(1, 14);
			if (snk_gap > 0) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Monitor and prediction at the rising edge.
	always @(posedge clk) begin
		nearest_t got, want;
		query_t q;
		took = arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			got.dist_res = m_tdata[32:0];
			got.fx = m_tdata[64:33];
			got.fy = m_tdata[96:65];
			got.param = m_tdata[113:97];
			got.degen = m_tuser;
			if (nearest_q.size() == 0) begin
				report("unexpected transfer", m_tdata[113:0], '0);
			end else begin
				want = nearest_q.pop_front();
				if (got.dist_res !== want.dist_res)
					report("dist_res", got.dist_res, want.dist_res);
				if (got.fx !== want.fx) report("foot_x", got.fx, want.fx);
				if (got.fy !== want.fy) report("foot_y", got.fy, want.fy);
				if (got.param !== want.param)
					report("segment_param", got.param, want.param);
				if (got.degen !== want.degen)
					report("degenerate", got.degen, want.degen);
			end
			checked++;
		end
		if (took) begin
			{q.ey, q.ex, q.sy, q.sx, q.qy, q.qx} = s_tdata;
			want = nearest_point(q);
			nearest_q.push_back(want);
			if (want.degen) n_degen++;
			else if (want.param == 0) n_low++;
			else if (want.param == 17'd65536) n_high++;
			else n_mid++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, nearest_q.size());
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		query_t mark;
		longint mx, mn;
		mx = 64'sh7fffffff;
		mn = -64'sh80000000;
		mark = mk(0, 0, 0, 0, 0, 0);
		mark.hold = 1;
		// directed: extremes, clamping on both ends, degenerate segments
		pending_q.push_back(mk(0, 0, 0, 0, 0, 0));
		pending_q.push_back(mk(mx, mx, 5, -7, 5, -7));
		pending_q.push_back(mk(mn, mn, mx, mx, mx, mx));
		pending_q.push_back(mk(mx, mx, mn, mn, mn, mn + 1));
		pending_q.push_back(mk(mx, mx, mn, mn, mn + 1, mn));
		pending_q.push_back(mk(mn, mx, mx, mn, mn, mx));
		pending_q.push_back(mk(mx, mn, mn, mx, mx, mn));
		pending_q.push_back(mk(mx, mx, mn, mn, mx, mx));
		pending_q.push_back(mk(mn, mn, mn, mn, mx, mx));
		pending_q.push_back(mk(-100, 3, 0, 0, 1000, 0));   // behind the start
		pending_q.push_back(mk(5000, 3, 0, 0, 1000, 0));   // past the end
		pending_q.push_back(mk(1000, 77, 0, 0, 1000, 0));  // projection exactly at end
		pending_q.push_back(mk(0, 77, 0, 0, 1000, 0));     // projection exactly at start
		pending_q.push_back(mk(500, 500, 0, 0, 1000, 0));
		pending_q.push_back(mk(1, 2, 0, 0, 3, 7));
		pending_q.push_back(mk(-1, -1, 1, -1, -1, 1));
		pending_q.push_back(mk(65536, 65536, 0, 0, 196608, 131072));
		pending_q.push_back(mk(mx, mn, 0, mx, 0, mn));
		pending_q.push_back(mk(-1, -1, -1, -1, 0, 0));
		pending_q.push_back(mk(0, 0, -1, -1, -1, -1));
		pending_q.push_back(mark);
		for (int i = 0; i < 1200; i++) begin
			pending_q.push_back(rnd_query());
			if (i == 600) pending_q.push_back(mark);
		end
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (pending_q.size() == 0 && !holding);
		do @(negedge clk); while (s_tvalid || nearest_q.size() != 0);
		repeat (100) @(posedge clk);
		$display("checked %0d results: %0d zero-length, %0d clamped at start,",
			checked, n_degen, n_low);
		$display("%0d clamped at end, %0d interior projections", n_high, n_mid);
		if (errors == 0 && nearest_q.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
